FILE: src/plp_pkg.sv
`default_nettype none
package plp_pkg;

    // Default depth of the trailing whitespace buffer
    localparam int PENDING_DEPTH_DEF = 16;

    // Characters with a meaning of their own on a properties line
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // What one accepted item asks for on the output side
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_CHAR,
        ACT_EOL
    } t_plp_act;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic ld_flush;
        logic ld_char;
        logic ld_eol;
    } t_plp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_plp_act act;
        logic     flush_req;
        logic     flush_last;
        logic     slot_free;
    } t_plp_sts;

endpackage
`default_nettype wire

FILE: src/properties_line_parser.sv
`default_nettype none
// Properties line parser. Each input transfer carries one character of a line in
// s_axis_tdata, or closes the line when s_axis_tlast is high. Key and value characters
// come out trimmed and tagged (tuser[0] high for the value), and each line ends with one
// result with tuser[1] high whose tdata[8] is 1 for a comment line. Trailing blanks wait
// in a buffer of PENDING_DEPTH entries and are replayed ahead of the next non-blank
// character of the same field; blanks that find the buffer full are lost and tdata[9] is
// set for the rest of the line. An item that yields no result leaves the input ready;
// one that yields a character holds input off while its buffered blanks are replayed,
// one per cycle from the buffer's single read port while the output takes them, and
// the character is sent; a line end holds input off until its result is loaded.
module properties_line_parser
    import plp_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tlast,   // line_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_char, [8] line_status, [9] overflow
    output logic [1:0]       m_axis_tuser,   // [0] in_value, [1] is_line_end
    output logic             m_axis_tlast    // last
);

    t_plp_cmd   cmd;
    t_plp_sts   sts;
    logic [7:0] out_char;
    logic       in_value, is_line_end, line_status, overflow;

    plp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    plp_dp #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch          (s_axis_tdata),
        .i_line_end    (s_axis_tlast),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_char    (out_char),
        .o_in_value    (in_value),
        .o_is_line_end (is_line_end),
        .o_line_status (line_status),
        .o_overflow    (overflow),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, overflow, line_status, out_char};
    assign m_axis_tuser = {is_line_end, in_value};

endmodule
`default_nettype wire

FILE: src/plp_ctrl.sv
`default_nettype none
module plp_ctrl
    import plp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_plp_sts i_sts,
    output t_plp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_CHAR,
        S_EOL
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    assign o_in_ready = r_ready;

    // Sequencing: take an item, then flush buffered blanks and send the character, or send the line end
    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = i_in_valid & r_ready;
        n_state      = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    unique case (i_sts.act)
                        ACT_CHAR: n_state = i_sts.flush_req ? S_FLUSH : S_CHAR;
                        ACT_EOL:  n_state = S_EOL;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_FLUSH: begin
                if (i_sts.slot_free) begin
                    o_cmd.ld_flush = 1'b1;
                    if (i_sts.flush_last) begin
                        n_state = S_CHAR;
                    end
                end
            end
            S_CHAR: begin
                if (i_sts.slot_free) begin
                    o_cmd.ld_char = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_EOL: begin
                if (i_sts.slot_free) begin
                    o_cmd.ld_eol = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule
`default_nettype wire

FILE: src/plp_dp.sv
`default_nettype none
module plp_dp
    import plp_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_line_end,
    input  wire t_plp_cmd   i_cmd,
    output t_plp_sts        o_sts,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_out_char,
    output logic            o_in_value,
    output logic            o_is_line_end,
    output logic            o_line_status,
    output logic            o_overflow,
    output logic            o_last
);

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    typedef enum logic [1:0] {
        PH_BEFORE,
        PH_KEY,
        PH_VALUE,
        PH_COMMENT
    } t_phase;

    // Line state
    t_phase           r_phase, n_phase;
    logic             r_esc, n_esc;
    logic             r_fs, n_fs;
    logic             r_ns, n_ns;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [1:0]       r_len, n_len;
    logic             r_first_lf, n_first_lf;

    // Item result held for the output sequence
    logic [7:0]       r_char;
    logic             r_res_val;
    logic             r_res_ovf;
    logic             r_status;
    logic [CNT_W-1:0] r_flush_cnt;

    // Whitespace buffer and flush pointer
    logic [7:0]       r_mem [PENDING_DEPTH];
    logic [7:0]       r_rd_data;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             flush_last;

    // Output register
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_val, r_out_eol, r_out_status, r_out_ovf, r_out_last;
    logic             slot_free;

    t_plp_act         act;
    logic             do_store, wr_en, is_ws, is_sep, is_cmt, eol_status;

    assign is_ws  = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
    assign is_sep = (i_ch == CH_EQ) || (i_ch == CH_COLON);
    assign is_cmt = (i_ch == CH_HASH) || (i_ch == CH_BANG);
    assign eol_status = (r_phase == PH_COMMENT) || ((r_len == 2'd1) && r_first_lf);

    // Outcome of the item on the input port
    always_comb begin
        n_phase    = r_phase;
        n_esc      = r_esc;
        n_fs       = r_fs;
        n_ns       = r_ns;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_len      = r_len;
        n_first_lf = r_first_lf;
        act        = ACT_NONE;
        do_store   = 1'b0;
        wr_en      = 1'b0;
        if (i_line_end) begin
            act        = ACT_EOL;
            n_phase    = PH_BEFORE;
            n_esc      = 1'b0;
            n_fs       = 1'b0;
            n_ns       = 1'b0;
            n_cnt      = '0;
            n_ovf      = 1'b0;
            n_len      = 2'd0;
            n_first_lf = 1'b0;
        end else if (i_ch != CH_NUL) begin
            if (r_len == 2'd0) begin
                n_first_lf = (i_ch == CH_LF);
            end
            if (r_len != 2'd2) begin
                n_len = r_len + 2'd1;
            end
            if ((r_phase != PH_COMMENT) &&
                !((r_phase == PH_BEFORE) && ((i_ch == CH_SPACE) || (i_ch == CH_TAB)))) begin
                if (r_phase == PH_BEFORE) begin
                    n_phase = PH_KEY;
                end
                if (is_sep || is_cmt) begin
                    if (r_esc) begin
                        do_store = 1'b1;
                        n_esc    = 1'b0;
                    end else if (is_cmt) begin
                        if (!r_fs) begin
                            n_phase = PH_COMMENT;
                        end else begin
                            do_store = 1'b1;
                        end
                    end else if (r_phase == PH_VALUE) begin
                        do_store = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end else if (i_ch == CH_BSLASH) begin
                    if (r_esc) begin
                        do_store = 1'b1;
                        n_esc    = 1'b0;
                    end else begin
                        n_esc = 1'b1;
                    end
                end else begin
                    n_esc    = 1'b0;
                    do_store = 1'b1;
                end
            end
            // Separator starts the value field afresh
            if (!do_store && is_sep && !r_esc && (r_phase != PH_COMMENT) &&
                (r_phase != PH_VALUE) && (n_phase == PH_VALUE)) begin
                n_fs  = 1'b0;
                n_ns  = 1'b0;
                n_cnt = '0;
            end
            if (do_store) begin
                n_fs = 1'b1;
                if (is_ws) begin
                    if (r_ns) begin
                        if (r_cnt < CNT_W'(PENDING_DEPTH)) begin
                            wr_en = 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end else begin
                    act   = ACT_CHAR;
                    n_cnt = '0;
                    n_ns  = 1'b1;
                end
            end
        end
    end

    assign slot_free  = !r_out_valid || i_out_ready;
    assign flush_last = ((CNT_W'(r_idx) + 1'b1) == r_flush_cnt);

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.ld_flush) begin
            n_idx = flush_last ? '0 : r_idx + 1'b1;
        end
    end

    assign o_sts.act        = act;
    assign o_sts.flush_req  = (act == ACT_CHAR) && (r_cnt != '0);
    assign o_sts.flush_last = flush_last;
    assign o_sts.slot_free  = slot_free;

    // Line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_BEFORE;
            r_esc      <= 1'b0;
            r_fs       <= 1'b0;
            r_ns       <= 1'b0;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_len      <= 2'd0;
            r_first_lf <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.accept) begin
                r_phase    <= n_phase;
                r_esc      <= n_esc;
                r_fs       <= n_fs;
                r_ns       <= n_ns;
                r_cnt      <= n_cnt;
                r_ovf      <= n_ovf;
                r_len      <= n_len;
                r_first_lf <= n_first_lf;
            end
        end
    end

    // Per-item result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char      <= i_ch;
            r_res_val   <= !i_line_end && (n_phase == PH_VALUE);
            r_res_ovf   <= i_line_end ? r_ovf : n_ovf;
            r_status    <= eol_status;
            r_flush_cnt <= r_cnt;
        end
    end

    // Whitespace buffer, registered read at the flush pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_mem[r_cnt[IDX_W-1:0]] <= i_ch;
        end
        r_rd_data <= r_mem[n_idx];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_flush || i_cmd.ld_char || i_cmd.ld_eol) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_flush) begin
            r_out_char   <= r_rd_data;
            r_out_val    <= r_res_val;
            r_out_eol    <= 1'b0;
            r_out_status <= 1'b0;
            r_out_ovf    <= r_res_ovf;
            r_out_last   <= 1'b0;
        end else if (i_cmd.ld_char) begin
            r_out_char   <= r_char;
            r_out_val    <= r_res_val;
            r_out_eol    <= 1'b0;
            r_out_status <= 1'b0;
            r_out_ovf    <= r_res_ovf;
            r_out_last   <= 1'b1;
        end else if (i_cmd.ld_eol) begin
            r_out_char   <= CH_NUL;
            r_out_val    <= 1'b0;
            r_out_eol    <= 1'b1;
            r_out_status <= r_status;
            r_out_ovf    <= r_res_ovf;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_in_value    = r_out_val;
    assign o_is_line_end = r_out_eol;
    assign o_line_status = r_out_status;
    assign o_overflow    = r_out_ovf;
    assign o_last        = r_out_last;

endmodule
`default_nettype wire

FILE: src/plp_checker.sv
`default_nettype none
module plp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A line end drops input ready after it is taken
    a_eol_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken behind a line end");

    // The line-end result closes the item
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("line-end result not last");

    // The line-end result carries no character
    a_eol_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[7:0] == 8'h00) && !m_axis_tuser[0])
        else $error("line-end result carries a character");

    // Character results carry no line status and a nonzero character
    a_char_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> !m_axis_tdata[8] && (m_axis_tdata[7:0] != 8'h00))
        else $error("character result malformed");

endmodule

bind properties_line_parser plp_checker u_plp_checker (.*);
`default_nettype wire

FILE: dv/properties_line_parser_tb.sv
`timescale 1ns / 1ps

module properties_line_parser_tb;
    import plp_pkg::*;

    localparam int PEND_DEPTH = PENDING_DEPTH_DEF;
    localparam int DIR_N      = 25;
    localparam int RAND_ITEMS = 385;
    localparam int DRAIN_CYC  = 20;
    localparam int TIMEOUT_NS = 1_000_000;

    // Parser phases
    localparam logic [1:0] PH_BEFORE_KEY = 2'd0;
    localparam logic [1:0] PH_KEY        = 2'd1;
    localparam logic [1:0] PH_VALUE      = 2'd2;
    localparam logic [1:0] PH_COMMENT    = 2'd3;

    // Line status codes
    localparam logic ST_PAIR    = 1'b0;
    localparam logic ST_COMMENT = 1'b1;

    // Blanks missing from the package
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    // One output transfer, unpacked from tdata/tuser/tlast
    typedef struct packed {
        logic [7:0] chr;
        logic       in_val;
        logic       eol;
        logic       status;
        logic       ovf;
        logic       last;
    } t_line_res;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       typed;
        t_line_res  res;
    } t_dir_row;

    localparam t_line_res NO_RES = '0;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] ch
    logic        s_axis_tlast  = 1'b0;    // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [7:0] out_char, [8] line_status, [9] overflow
    logic [1:0]  m_axis_tuser;            // [0] in_value, [1] is_line_end
    logic        m_axis_tlast;

    properties_line_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Parser state mirrored on the testbench side
    logic [1:0] ph;
    logic       esc_pend;
    logic       fld_started;
    logic       nonsp_seen;
    logic       ovf_seen;
    logic       first_lf;
    logic [7:0] blank_buf [PEND_DEPTH];
    int         blank_cnt;
    int         line_len;

    t_line_res step_out [$];     // results of the item being parsed
    t_line_res line_out_q [$];   // characters and statuses still to arrive

    int  n_errors    = 0;
    int  n_items     = 0;
    int  n_lines     = 0;
    int  n_results   = 0;
    int  n_comments  = 0;
    int  n_ovf_lines = 0;
    int  max_burst   = 0;
    bit  quiet_in    = 1'b0;
    bit  quiet_out   = 1'b0;

    t_dir_row dir_tab [DIR_N] = '{
        // empty line straight after reset
        '{CH_NUL,    1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, ST_PAIR, 1'b0, 1'b1}},
        // lone LF line
        '{CH_LF,     1'b0, 1'b0, NO_RES},
        '{CH_NUL,    1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, ST_COMMENT, 1'b0, 1'b1}},
        // comment at key start swallows the rest
        '{CH_HASH,   1'b0, 1'b0, NO_RES},
        '{8'h71,     1'b0, 1'b0, NO_RES},
        '{CH_NUL,    1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, ST_COMMENT, 1'b0, 1'b1}},
        // leading tab skipped, first key character
        '{CH_TAB,    1'b0, 1'b0, NO_RES},
        '{8'h61,     1'b0, 1'b1, '{8'h61, 1'b0, 1'b0, ST_PAIR, 1'b0, 1'b1}},
        // pending blank flushed ahead of escaped separator
        '{CH_SPACE,  1'b0, 1'b0, NO_RES},
        '{CH_BSLASH, 1'b0, 1'b0, NO_RES},
        '{CH_EQ,     1'b0, 1'b0, NO_RES},
        // backslash before an ordinary character is dropped
        '{CH_BSLASH, 1'b0, 1'b0, NO_RES},
        '{8'h78,     1'b0, 1'b0, NO_RES},
        // separator, zero byte, later separator is plain value text
        '{CH_COLON,  1'b0, 1'b0, NO_RES},
        '{CH_NUL,    1'b0, 1'b0, NO_RES},
        '{CH_EQ,     1'b0, 1'b0, NO_RES},
        '{8'hFF,     1'b0, 1'b0, NO_RES},
        // double backslash, trailing blank, dangling backslash at line end
        '{CH_BSLASH, 1'b0, 1'b0, NO_RES},
        '{CH_BSLASH, 1'b0, 1'b0, NO_RES},
        '{CH_CR,     1'b0, 1'b0, NO_RES},
        '{CH_BSLASH, 1'b0, 1'b0, NO_RES},
        '{CH_NUL,    1'b1, 1'b0, NO_RES},
        // comment mark at value start
        '{CH_COLON,  1'b0, 1'b0, NO_RES},
        '{CH_BANG,   1'b0, 1'b0, NO_RES},
        '{8'h80,     1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, ST_COMMENT, 1'b0, 1'b1}}
    };

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void put_res(logic [7:0] c, logic eol, logic st);
        t_line_res r;
        r.chr    = c;
        r.in_val = !eol && ph == PH_VALUE;
        r.eol    = eol;
        r.status = st;
        r.ovf    = ovf_seen;
        r.last   = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void clear_line_state();
        ph          = PH_BEFORE_KEY;
        esc_pend    = 1'b0;
        fld_started = 1'b0;
        nonsp_seen  = 1'b0;
        ovf_seen    = 1'b0;
        first_lf    = 1'b0;
        blank_cnt   = 0;
        line_len    = 0;
    endfunction

    // Store into the current field: blanks wait, anything else flushes them
    function automatic void store_char(logic [7:0] c);
        fld_started = 1'b1;
        if (is_blank(c)) begin
            if (!nonsp_seen)
                return;
            if (blank_cnt < PEND_DEPTH) begin
                blank_buf[blank_cnt] = c;
                blank_cnt++;
            end else begin
                ovf_seen = 1'b1;
            end
            return;
        end
        for (int i = 0; i < blank_cnt; i++)
            put_res(blank_buf[i], 1'b0, ST_PAIR);
        blank_cnt = 0;
        put_res(c, 1'b0, ST_PAIR);
        nonsp_seen = 1'b1;
    endfunction

    // Parse one accepted input item into step_out (last flag set by the caller)
    function automatic void parse_step(logic [7:0] c, logic eol);
        step_out.delete();
        if (eol) begin
            put_res(CH_NUL, 1'b1,
                    (ph == PH_COMMENT || (line_len == 1 && first_lf)) ? ST_COMMENT : ST_PAIR);
            clear_line_state();
            return;
        end
        if (c == CH_NUL)
            return;
        if (line_len == 0)
            first_lf = (c == CH_LF);
        if (line_len < 2)
            line_len++;
        if (ph == PH_COMMENT)
            return;
        if (ph == PH_BEFORE_KEY) begin
            if (c == CH_SPACE || c == CH_TAB)
                return;
            ph = PH_KEY;
        end
        if (c == CH_EQ || c == CH_COLON || c == CH_HASH || c == CH_BANG) begin
            if (esc_pend) begin
                store_char(c);
                esc_pend = 1'b0;
            end else if (c == CH_HASH || c == CH_BANG) begin
                if (!fld_started)
                    ph = PH_COMMENT;
                else
                    store_char(c);
            end else if (ph == PH_VALUE) begin
                store_char(c);
            end else begin
                // separator: value starts fresh, key blanks discarded
                ph          = PH_VALUE;
                fld_started = 1'b0;
                nonsp_seen  = 1'b0;
                blank_cnt   = 0;
            end
        end else if (c == CH_BSLASH) begin
            if (esc_pend) begin
                store_char(c);
                esc_pend = 1'b0;
            end else begin
                esc_pend = 1'b1;
            end
        end else begin
            esc_pend = 1'b0;
            store_char(c);
        end
    endfunction

    // Drive one input transfer, then queue what it should produce
    task automatic send_item(logic [7:0] c, logic eol, logic typed, t_line_res typed_res);
        int        gap;
        t_line_res r;
        gap = quiet_in ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eol;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        parse_step(c, eol);
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
        if (step_out.size() > max_burst)
            max_burst = step_out.size();
        if (eol) begin
            n_lines++;
            if (step_out[0].status == ST_COMMENT)
                n_comments++;
            if (step_out[0].ovf)
                n_ovf_lines++;
        end
        if (typed)
            line_out_q.push_back(typed_res);
        else
            foreach (step_out[i])
                line_out_q.push_back(step_out[i]);
        if (eol || c != CH_NUL)
            n_items++;
    endtask

    task automatic put_ch(logic [7:0] c);
        send_item(c, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic put_eol();
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_RES);
    endtask

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] letter();
        return 8'(8'h41 + $urandom_range(0, 25));
    endfunction

    // Mostly printable text, some high bytes, blanks, controls and marks
    function automatic logic [7:0] text_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 8'($urandom_range(8'h21, 8'h7E));
        if (r < 75)
            return 8'($urandom_range(8'h80, 8'hFF));
        if (r < 85)
            return any_blank();
        if (r < 90)
            return 8'($urandom_range(8'h0E, 8'h1F));
        case ($urandom_range(0, 3))
            0:       return CH_EQ;
            1:       return CH_COLON;
            2:       return CH_HASH;
            default: return CH_BANG;
        endcase
    endfunction

    task automatic send_field(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                put_ch(CH_BSLASH);
            put_ch(text_char());
        end
    endtask

    task automatic long_blank_run();
        repeat ($urandom_range(10, 20)) put_ch(any_blank());
    endtask

    // One random line, mostly well formed
    task automatic random_line();
        int unsigned kind;
        kind     = $urandom_range(0, 99);
        quiet_in = ($urandom_range(0, 4) == 0);
        if (kind < 60) begin
            repeat ($urandom_range(0, 3)) put_ch($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            send_field($urandom_range(0, 6));
            repeat ($urandom_range(0, 2)) put_ch(any_blank());
            put_ch($urandom_range(0, 1) ? CH_EQ : CH_COLON);
            repeat ($urandom_range(0, 2)) put_ch(any_blank());
            send_field($urandom_range(0, 8));
            repeat ($urandom_range(0, 3)) put_ch(any_blank());
            put_eol();
        end else if (kind < 70) begin
            // long blank runs inside key and value, overflow and full flushes
            put_ch(letter());
            long_blank_run();
            put_ch(letter());
            if ($urandom_range(0, 1)) begin
                put_ch(CH_EQ);
                put_ch(letter());
                long_blank_run();
                put_ch(letter());
            end
            put_eol();
        end else if (kind < 78) begin
            repeat ($urandom_range(0, 2)) put_ch($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            put_ch($urandom_range(0, 1) ? CH_HASH : CH_BANG);
            send_field($urandom_range(0, 5));
            put_eol();
        end else if (kind < 84) begin
            case ($urandom_range(0, 3))
                0: ;
                1: put_ch(CH_LF);
                2: begin
                    put_ch(CH_LF);
                    put_ch(letter());
                end
                default: begin
                    put_ch($urandom_range(0, 1) ? CH_VT : CH_FF);
                    send_field($urandom_range(1, 4));
                end
            endcase
            put_eol();
        end else begin
            // raw bytes, line ends anywhere
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 7) == 0)
                    put_eol();
                else
                    put_ch(8'($urandom_range(0, 255)));
            end
        end
    endtask

    function automatic void cmp_field(string fname, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
        end
    endfunction

    // Output side: random stalls, every transfer checked against the oldest expectation
    initial begin
        int        gap;
        t_line_res exp_r;
        forever begin
            if ($urandom_range(0, 15) == 0)
                quiet_out = !quiet_out;
            gap = quiet_out ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1 || !i_rst_n);
            n_results++;
            if (line_out_q.size() == 0) begin
                n_errors++;
                $display("%0t: expected no result, actual tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                exp_r = line_out_q.pop_front();
                cmp_field("out_char",    exp_r.chr,        m_axis_tdata[7:0]);
                cmp_field("in_value",    8'(exp_r.in_val), 8'(m_axis_tuser[0]));
                cmp_field("is_line_end", 8'(exp_r.eol),    8'(m_axis_tuser[1]));
                cmp_field("line_status", 8'(exp_r.status), 8'(m_axis_tdata[8]));
                cmp_field("overflow",    8'(exp_r.ovf),    8'(m_axis_tdata[9]));
                cmp_field("last",        8'(exp_r.last),   8'(m_axis_tlast));
            end
        end
    end

    // Stimulus: reset, directed table, random lines, drain
    initial begin
        clear_line_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            quiet_in = ($urandom_range(0, 2) == 0);
            send_item(dir_tab[i].ch, dir_tab[i].eol, dir_tab[i].typed, dir_tab[i].res);
        end

        while (n_items < DIR_N + RAND_ITEMS)
            random_line();
        // close whatever line the noise left open
        put_eol();
        s_axis_tvalid <= 1'b0;

        while (line_out_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (line_out_q.size() > 0) begin
            n_errors += line_out_q.size();
            $display("%0t: %0d expected results never arrived", $time, line_out_q.size());
        end

        $display("%0d items over %0d lines, %0d results checked, up to %0d from one item",
                 n_items, n_lines, n_results, max_burst);
        $display("%0d comment lines, %0d lines with blank buffer overflow, %0d errors",
                 n_comments, n_ovf_lines, n_errors);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d results still expected", $time, line_out_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
src/plp_pkg.sv
src/plp_ctrl.sv
src/plp_dp.sv
src/properties_line_parser.sv
src/plp_checker.sv
dv/properties_line_parser_tb.sv
